>>> rtl/gwsd_pkg.sv
// shared types and constants of the gated window sensor debouncer
`timescale 1ns / 1ps
package gwsd_pkg;

	localparam int SENSOR_W  = 7;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 1;
	localparam int COUNT_W   = 8;

	typedef logic [SENSOR_W-1:0]  sensor_vec_t;
	typedef logic [CFG_W-1:0]     cfg_data_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [COUNT_W-1:0]   count_t;

	// operation codes of an input transaction
	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// register indexes on the configuration channel
	localparam cfg_idx_t REG_WINDOW_TICKS   = 1'b0;
	localparam cfg_idx_t REG_STABLE_WINDOWS = 1'b1;

	localparam cfg_data_t WINDOW_TICKS_RST   = 8'd4;
	localparam cfg_data_t STABLE_WINDOWS_RST = 8'd2;
	localparam count_t    COUNT_MAX          = 8'hFF;

endpackage

>>> rtl/gwsd_item_if.sv
// input channel carrying edge and tick events
`timescale 1ns / 1ps
interface gwsd_item_if;
	import gwsd_pkg::*;

	logic        valid;
	logic        ready;
	logic        operation;
	sensor_vec_t sensor_bits;

	modport source (output valid, output operation, output sensor_bits, input ready);
	modport sink (input valid, input operation, input sensor_bits, output ready);
endinterface

>>> rtl/gwsd_result_if.sv
// output channel carrying debounced status results
`timescale 1ns / 1ps
interface gwsd_result_if;
	import gwsd_pkg::*;

	logic        valid;
	logic        ready;
	sensor_vec_t status_bits;
	logic        awaiting_edge;
	logic        window_done;
	logic        edge_missing;
	logic        all_off;

	modport source (output valid, output status_bits, output awaiting_edge,
		output window_done, output edge_missing, output all_off, input ready);
	modport sink (input valid, input status_bits, input awaiting_edge,
		input window_done, input edge_missing, input all_off, output ready);
endinterface

>>> rtl/gwsd_cfg_if.sv
// configuration write channel
`timescale 1ns / 1ps
interface gwsd_cfg_if;
	import gwsd_pkg::*;

	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/gated_window_sensor_debouncer_top.sv
// top level of the gated window sensor debouncer
`timescale 1ns / 1ps
// usage
//   items   : one transaction per event, operation selects light edge or sample tick,
//             sensor_bits carries the raw sensor levels used on ticks
//   results : exactly one transaction per accepted item, in order, with the debounced
//             status, the awaiting-edge flag, window-done, edge-missing and all-off
//   cfg     : register writes (window_ticks, stable_windows), always ready; write only
//             while the block is idle
// timing
//   the result of an accepted item is registered and valid in the cycle after acceptance
//   throughput is one item per cycle unless results stall; the whole state update is
//   one short pass of logic from the state registers into the state and result registers
// reset
//   arst_n clears all debounce state, sets the block to await a light edge and loads
//   window_ticks = 4, stable_windows = 2; no result is pending after reset
// stalls
//   the result register holds while results.ready is low; items.ready stays high as
//   long as the result register is empty or is being drained in the same cycle
module gated_window_sensor_debouncer_top #(
	parameter int NUM_SENSORS = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	gwsd_item_if.sink            items,
	gwsd_result_if.source        results,
	gwsd_cfg_if.sink             cfg
);
	import gwsd_pkg::*;

	localparam int NS = NUM_SENSORS;

	// configuration registers
	cfg_data_t win_ticks_q;
	cfg_data_t stable_q;

	// debounce state
	logic [NS-1:0] status_q;
	logic [NS-1:0] last_q;
	logic [NS-1:0] sticky_q;
	count_t        run_q [NS];
	count_t        tick_q;
	logic          wait_q;

	// next state
	logic [NS-1:0] status_d;
	logic [NS-1:0] last_d;
	logic [NS-1:0] sticky_d;
	count_t        run_d [NS];
	count_t        tick_d;
	logic          wait_d;
	logic          done_d;
	logic          missing_d;

	// result register
	logic        res_valid_q;
	sensor_vec_t res_status_q;
	logic        res_wait_q;
	logic        res_done_q;
	logic        res_missing_q;
	logic        res_all_off_q;

	logic        item_acc;
	logic [NS+SENSOR_W-1:0] smp_pad;
	logic [NS-1:0]          smp;
	logic [NS+SENSOR_W-1:0] shown_pad;
	sensor_vec_t            shown;

	// accept a new item whenever the result slot is free or draining now
	assign items.ready = !res_valid_q || results.ready;
	assign item_acc    = items.valid && items.ready;
	assign cfg.ready   = 1'b1;

	// channels beyond the input width sample zero
	assign smp_pad = {{NS{1'b0}}, items.sensor_bits};
	assign smp     = smp_pad[NS-1:0];

	// only the low channels are visible, missing ones read as zero
	assign shown_pad = {{SENSOR_W{1'b0}}, status_d};
	assign shown     = shown_pad[SENSOR_W-1:0];

	always_comb begin
		logic [NS-1:0] sticky_n;
		count_t        tick_inc;
		count_t        rc;
		status_d  = status_q;
		last_d    = last_q;
		sticky_d  = sticky_q;
		run_d     = run_q;
		tick_d    = tick_q;
		wait_d    = wait_q;
		done_d    = 1'b0;
		missing_d = 1'b0;
		sticky_n  = sticky_q | smp;
		tick_inc  = (tick_q == COUNT_MAX) ? tick_q : tick_q + 8'd1;
		rc        = '0;
		if (item_acc) begin
			if (items.operation == OP_EDGE) begin
				// an edge opens a window; while sampling it changes nothing
				wait_d = 1'b0;
			end else if (wait_q) begin
				missing_d = 1'b1;
			end else if (tick_inc >= win_ticks_q) begin
				// window closes: debounce every channel on its sticky value
				for (int ch = 0; ch < NS; ch++) begin
					rc = (run_q[ch] == COUNT_MAX) ? COUNT_MAX : run_q[ch] + 8'd1;
					if (sticky_n[ch] != last_q[ch]) begin
						rc = '0;
					end
					if (rc >= stable_q) begin
						status_d[ch] = sticky_n[ch];
					end
					run_d[ch] = rc;
				end
				last_d   = sticky_n;
				sticky_d = '0;
				tick_d   = '0;
				wait_d   = 1'b1;
				done_d   = 1'b1;
			end else begin
				sticky_d = sticky_n;
				tick_d   = tick_inc;
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_ticks_q <= WINDOW_TICKS_RST;
			stable_q    <= STABLE_WINDOWS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_WINDOW_TICKS:   win_ticks_q <= cfg.data;
				REG_STABLE_WINDOWS: stable_q    <= cfg.data;
				default: ;
			endcase
		end
	end

	// debounce state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
			last_q   <= '0;
			sticky_q <= '0;
			for (int ch = 0; ch < NS; ch++) begin
				run_q[ch] <= '0;
			end
			tick_q   <= '0;
			wait_q   <= 1'b1;
		end else begin
			status_q <= status_d;
			last_q   <= last_d;
			sticky_q <= sticky_d;
			run_q    <= run_d;
			tick_q   <= tick_d;
			wait_q   <= wait_d;
		end
	end

	// result slot valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (item_acc) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload, loaded with each accepted transaction
	always_ff @(posedge clk) begin
		if (item_acc) begin
			res_status_q  <= shown;
			res_wait_q    <= wait_d;
			res_done_q    <= done_d;
			res_missing_q <= missing_d;
			res_all_off_q <= (shown == '0);
		end
	end

	assign results.valid         = res_valid_q;
	assign results.status_bits   = res_status_q;
	assign results.awaiting_edge = res_wait_q;
	assign results.window_done   = res_done_q;
	assign results.edge_missing  = res_missing_q;
	assign results.all_off       = res_all_off_q;

`ifndef NO_ASSERTIONS
	// no partial window count survives while awaiting an edge
	a_wait_tick_clear: assert property (@(posedge clk) disable iff (!arst_n)
		wait_q |-> (tick_q == '0))
		else $error("tick count nonzero while awaiting edge");

	// a closed window always returns the block to awaiting an edge
	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_done_q) |-> (res_wait_q && !res_missing_q))
		else $error("window done without awaiting edge");

	// a tick taken while awaiting an edge reports the missing edge
	a_tick_missing: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && items.operation == OP_TICK && wait_q) |=>
		(res_valid_q && res_missing_q && res_wait_q))
		else $error("missing edge not reported");

	// every accepted edge opens a window and reports no window done
	a_edge_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && items.operation == OP_EDGE) |=> (!wait_q && !res_done_q))
		else $error("edge did not open a window");

	// status changes only when a window closes
	a_status_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		(status_q != $past(status_q)) |-> $past(done_d))
		else $error("status changed outside window close");
`endif

endmodule
